@@ rtl/core/rtpj_pkg.sv @@
// ---------------------------------------------------------------------------
// rtpj_pkg
// Types, codes and constants shared by the RTP receive statistics block.
// ---------------------------------------------------------------------------
`default_nettype none

package rtpj_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam logic [7:0]  TICKS_RESET = 8'd8;
    localparam logic [10:0] HDR_BYTES   = 11'd12;
    localparam logic [1:0]  RTP_VERSION = 2'd2;
    localparam logic [30:0] MAG_MAX     = 31'h7FFF_FFFF;
    localparam int          SMOOTH_SHIFT = 4;
    localparam logic signed [32:0] SMOOTH_BIAS = 33'sd15;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_OPEN   = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_INACTIVE  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CMD_DONE  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  channel;
        logic [10:0] packet_length;
        logic [7:0]  header_first_byte;
        logic [15:0] sequence_number;
        logic [31:0] rtp_timestamp;
        logic [31:0] arrival_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] lost_now;
        logic [31:0] lost_total;
        logic [31:0] received_total;
        logic [30:0] jitter_units;
        logic [30:0] transit_variation;
    } result_t;

    // one channel record as kept in the statistics memory
    typedef struct packed {
        logic [31:0] received;
        logic [31:0] lost;
        logic [15:0] prev_seq;
        logic [31:0] prev_rtp;
        logic [31:0] prev_arrival;
        logic [31:0] jitter;
    } stats_rec_t;

endpackage

`default_nettype wire

@@ rtl/core/rtpj_if.sv @@
// ---------------------------------------------------------------------------
// rtpj_if
// Valid/ready channels of the RTP receive statistics block.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtpj_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [10:0] packet_length;
    logic [7:0]  header_first_byte;
    logic [15:0] sequence_number;
    logic [31:0] rtp_timestamp;
    logic [31:0] arrival_ms;

    modport source (
        output valid, action, channel, packet_length, header_first_byte,
               sequence_number, rtp_timestamp, arrival_ms,
        input  ready
    );
    modport sink (
        input  valid, action, channel, packet_length, header_first_byte,
               sequence_number, rtp_timestamp, arrival_ms,
        output ready
    );
endinterface

interface rtpj_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] lost_now;
    logic [31:0] lost_total;
    logic [31:0] received_total;
    logic [30:0] jitter_units;
    logic [30:0] transit_variation;

    modport source (
        output valid, status, lost_now, lost_total, received_total,
               jitter_units, transit_variation,
        input  ready
    );
    modport sink (
        input  valid, status, lost_now, lost_total, received_total,
               jitter_units, transit_variation,
        output ready
    );
endinterface

interface rtpj_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rtpj_stats_mem.sv @@
// ---------------------------------------------------------------------------
// rtpj_stats_mem
// Per-channel statistics memory, one registered read port and one write
// port; entries not yet written since reset read as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module rtpj_stats_mem #(
    parameter int CHANNELS = rtpj_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output rtpj_pkg::stats_rec_t      rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire rtpj_pkg::stats_rec_t wr_data
);
    import rtpj_pkg::*;

    stats_rec_t            mem [CHANNELS];
    logic [CHANNELS-1:0]   vld_reg;
    stats_rec_t            rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/core/rtp_receive_loss_jitter_stats.sv @@
// ---------------------------------------------------------------------------
// rtp_receive_loss_jitter_stats
// Per-channel RTP receive statistics: packet counts, sequence-gap loss and
// RFC 3550 interarrival jitter, with channel open and close commands.
//
// item:   packet or command transfers (valid/ready), one result each
// result: status and the channel's statistics (valid/ready)
// cfg:    write of ticks_per_ms, taken at any time (ready is always high)
//
// An item passes through a channel record read from the statistics
// memory (registered), the arrival multiply by ticks_per_ms, then
// the update, write-back and load of the result register. One item is in
// work at a time: a new item is taken only once the last one has left
// its update step.
// The result register sits between the sides: a new item is taken while a
// result still waits; if the receiver stalls, the next item holds in its
// update step until the result register frees up.
// Reset clears all channels to inactive with zero statistics at once and
// sets ticks_per_ms to 8.
// ---------------------------------------------------------------------------
`default_nettype none

module rtp_receive_loss_jitter_stats #(
    parameter int CHANNELS = rtpj_pkg::CHANNELS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rtpj_cfg_if.sink       cfg,
    rtpj_item_if.sink      item,
    rtpj_result_if.source  result
);
    import rtpj_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          ticks_reg;
    logic [CHANNELS-1:0] active_reg, active_next;
    item_t               item_reg;
    logic [31:0]         prod_reg;
    logic [31:0]         dts_reg;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic                accept;
    logic                load_res;
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    stats_rec_t          rec;
    stats_rec_t          rec_new;
    logic                mem_we;

    logic [31:0]         recv_inc;
    logic [31:0]         var_val;
    logic [31:0]         mag_full;
    logic [30:0]         mag;
    logic signed [32:0]  jdiff;
    logic signed [32:0]  jquot;
    logic [15:0]         lost;
    logic                show;
    logic [2:0]          status;
    logic [15:0]         lost_out;
    logic [30:0]         tv_out;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            ticks_reg <= cfg.data;
        end
    end

    // item capture
    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action            <= item.action;
            item_reg.channel           <= item.channel;
            item_reg.packet_length     <= item.packet_length;
            item_reg.header_first_byte <= item.header_first_byte;
            item_reg.sequence_number   <= item.sequence_number;
            item_reg.rtp_timestamp     <= item.rtp_timestamp;
            item_reg.arrival_ms        <= item.arrival_ms;
        end
    end

    assign idx      = IDX_W'(item_reg.channel);
    assign in_range = (int'(item_reg.channel) < CHANNELS);

    rtpj_stats_mem #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (IDX_W'(item.channel)),
        .rd_data (rec),
        .wr_en   (mem_we),
        .wr_addr (idx),
        .wr_data (rec_new)
    );

    // arrival delta scaled to rtp clock units
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= 32'((item_reg.arrival_ms - rec.prev_arrival) * 32'(ticks_reg));
            dts_reg  <= item_reg.rtp_timestamp - rec.prev_rtp;
        end
    end

    // update step
    assign recv_inc = rec.received + 32'd1;
    assign var_val  = prod_reg - dts_reg;
    assign mag_full = var_val[31] ? (32'd0 - var_val) : var_val;
    assign mag      = mag_full[31] ? MAG_MAX : mag_full[30:0];
    assign jdiff    = $signed({2'b00, mag}) - $signed({rec.jitter[31], rec.jitter});
    assign jquot    = (jdiff + (jdiff[32] ? SMOOTH_BIAS : 33'sd0)) >>> SMOOTH_SHIFT;
    assign lost     = item_reg.sequence_number - rec.prev_seq - 16'd1;

    always_comb
    begin
        rec_new     = rec;
        active_next = active_reg;
        mem_we      = 1'b0;
        show        = 1'b0;
        status      = ST_CMD_DONE;
        lost_out    = '0;
        tv_out      = '0;
        unique case (action_t'(item_reg.action))
            ACT_PACKET:
            begin
                if (!in_range || !active_reg[idx])
                begin
                    status = ST_INACTIVE;
                end
                else if (item_reg.packet_length < HDR_BYTES)
                begin
                    status = ST_TOO_SHORT;
                    show   = 1'b1;
                end
                else if (item_reg.header_first_byte[7:6] != RTP_VERSION)
                begin
                    status = ST_BAD_VER;
                    show   = 1'b1;
                end
                else if (item_reg.packet_length == HDR_BYTES)
                begin
                    status = ST_EMPTY;
                    show   = 1'b1;
                end
                else
                begin
                    status           = ST_COUNTED;
                    show             = 1'b1;
                    mem_we           = 1'b1;
                    rec_new.received = recv_inc;
                    if (recv_inc > 32'd1)
                    begin
                        if ({1'b0, item_reg.sequence_number} > {1'b0, rec.prev_seq} + 17'd1)
                        begin
                            lost_out     = lost;
                            rec_new.lost = rec.lost + 32'(lost);
                        end
                        tv_out         = mag;
                        rec_new.jitter = rec.jitter + jquot[31:0];
                    end
                    rec_new.prev_seq     = item_reg.sequence_number;
                    rec_new.prev_rtp     = item_reg.rtp_timestamp;
                    rec_new.prev_arrival = item_reg.arrival_ms;
                end
            end
            ACT_OPEN:
            begin
                if (in_range)
                begin
                    show             = 1'b1;
                    mem_we           = 1'b1;
                    rec_new          = '0;
                    active_next[idx] = 1'b1;
                end
            end
            ACT_CLOSE:
            begin
                if (in_range)
                begin
                    show             = 1'b1;
                    active_next[idx] = 1'b0;
                end
            end
            ACT_NOP:
            begin
                show = in_range;
            end
        endcase
        if (!load_res)
        begin
            mem_we      = 1'b0;
            active_next = active_reg;
        end
    end

    assign load_res = (state_reg == S_UPD) && (!res_valid_reg || result.ready);

    always_comb
    begin
        res_next                   = res_reg;
        res_valid_next             = res_valid_reg;
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (load_res)
        begin
            res_valid_next             = 1'b1;
            res_next.status            = status;
            res_next.lost_now          = lost_out;
            res_next.lost_total        = show ? rec_new.lost : '0;
            res_next.received_total    = show ? rec_new.received : '0;
            res_next.jitter_units      = show ? rec_new.jitter[30:0] : '0;
            res_next.transit_variation = tv_out;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (load_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid             = res_valid_reg;
    assign result.status            = res_reg.status;
    assign result.lost_now          = res_reg.lost_now;
    assign result.lost_total        = res_reg.lost_total;
    assign result.received_total    = res_reg.received_total;
    assign result.jitter_units      = res_reg.jitter_units;
    assign result.transit_variation = res_reg.transit_variation;

    // checks
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MUL))
        else $error("accepted transfer did not start the record read");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_UPD) && load_res)
        else $error("statistics write outside the update step");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> result.valid && (state_reg == S_IDLE))
        else $error("update finished without a pending result");

endmodule

`default_nettype wire
